### src/tsbb_pkg.sv
// shared types, constants and the quarter-wave sine table for the turtle step block
`timescale 1ns / 1ps
`default_nettype none

package tsbb_pkg;

	localparam int NUM_TURNS       = 4;
	localparam int SINE_TABLE_BITS = 10;

	localparam int QSTEPS       = 1 << SINE_TABLE_BITS;
	localparam int SINE_ADDR_W  = SINE_TABLE_BITS + 1;
	localparam int SINE_MAG_W   = 17;
	localparam int TRIG_W       = SINE_MAG_W + 1;
	localparam int ANGLE_W      = 16;
	localparam int POS_W        = 32;
	localparam int TURN_IDX_W   = 2;
	localparam int TURN_SLOTS   = 1 << TURN_IDX_W;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int PROD_W       = 34;
	localparam int STEP_FRAC    = 8;
	localparam int DELTA_W      = PROD_W - STEP_FRAC;

	localparam logic [ANGLE_W-1:0]    COS_OFFSET        = 16'd16384;
	localparam logic [CFG_DATA_W-1:0] STEP_LENGTH_RESET = 16'd256;
	localparam logic [PROD_W-1:0]     ROUND_HALF        = 34'd128;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q16     = 64'd65536;
	localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TURN_A        = 3'd0,
		CFG_TURN_B        = 3'd1,
		CFG_TURN_C        = 3'd2,
		CFG_TURN_D        = 3'd3,
		CFG_START_HEADING = 3'd4,
		CFG_STEP_LENGTH   = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic [TURN_IDX_W-1:0] turn_index;
		logic                  restart;
	} in_word_t;

	typedef struct packed {
		logic signed [POS_W-1:0] point_x;
		logic signed [POS_W-1:0] point_y;
		logic signed [POS_W-1:0] center_x;
		logic signed [POS_W-1:0] center_y;
	} out_word_t;

	typedef logic [QSTEPS:0][SINE_MAG_W-1:0] sine_tab_t;

	// taylor series for sin over the first quarter, evaluated at elaboration
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t         tab;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint unsigned   v;
		longint            sum;
		tab = '0;
		for (int k = 0; k < QSTEPS; k++) begin
			x    = (HALF_PI_Q30 * longint'(k)) / QSTEPS;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 6; n++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
				if ((n & 1) != 0) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (longint'(sum) + 64'd8192) >> 14;
			if (v > ONE_Q16) begin
				v = ONE_Q16;
			end
			tab[k] = v[SINE_MAG_W-1:0];
		end
		tab[QSTEPS] = ONE_Q16[SINE_MAG_W-1:0];
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

### src/turtle_step_bounding_box.sv
// turtle path walker: heading accumulate, sine lookup, step and running bounding box
// an accepted word moves through the heading, sine, product and position registers into the output register
// throughput: one word per cycle while the output is taken; the heading loop closes at the input
// stage and the position/bounds loop closes at the accumulate stage
// the whole pipeline stalls only while the output register holds an untaken word
// reset: asynchronous, clears config to defaults; the first word after reset restarts
`timescale 1ns / 1ps
`default_nettype none

module turtle_step_bounding_box
	import tsbb_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire in_word_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output out_word_t                   out_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// configuration
	logic [ANGLE_W-1:0]    turn_angle_q [TURN_SLOTS];
	logic [ANGLE_W-1:0]    start_heading_q;
	logic [CFG_DATA_W-1:0] step_length_q;

	// heading loop
	logic [ANGLE_W-1:0] heading_q;
	logic               fresh_q;
	logic [ANGLE_W-1:0] base_heading;
	logic [ANGLE_W-1:0] turn;
	logic [ANGLE_W-1:0] next_heading;
	logic               advance;
	logic               in_acc;
	logic               clr_in;

	// pipeline
	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic               clr_s1, clr_s2, clr_s3;
	logic [ANGLE_W-1:0] heading_s1;
	logic signed [TRIG_W-1:0] sin_s2, cos_s2;
	logic signed [PROD_W-1:0] prod_x_s3, prod_y_s3;

	// position and bounds state
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic signed [POS_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [POS_W-1:0] pos_x_base, pos_y_base;
	logic signed [POS_W-1:0] min_x_base, max_x_base, min_y_base, max_y_base;
	logic signed [POS_W-1:0] pos_x_new, pos_y_new;
	logic signed [DELTA_W-1:0] delta_x, delta_y;

	// output register
	logic               out_valid_q;
	out_word_t          out_word_q;
	logic signed [POS_W:0] center_x_sum, center_y_sum;

	// round a Q24 product to Q16, floor after adding one half
	function automatic logic signed [DELTA_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		r = p + $signed(ROUND_HALF);
		return DELTA_W'(r >>> STEP_FRAC);
	endfunction

	function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] p,
			input logic signed [DELTA_W-1:0] d);
		logic signed [POS_W:0] s;
		s = {p[POS_W-1], p} + (POS_W+1)'(d);
		if (s[POS_W] != s[POS_W-1]) begin
			return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end
		return s[POS_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TURN_SLOTS; i++) begin
				turn_angle_q[i] <= '0;
			end
			start_heading_q <= '0;
			step_length_q   <= STEP_LENGTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index) inside
				CFG_TURN_A, CFG_TURN_B, CFG_TURN_C, CFG_TURN_D: begin
					turn_angle_q[cfg_index[TURN_IDX_W-1:0]] <= cfg_data;
				end
				CFG_START_HEADING: begin
					start_heading_q <= cfg_data;
				end
				CFG_STEP_LENGTH: begin
					step_length_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;
	assign in_acc   = in_valid && advance;
	assign clr_in   = in_data.restart || fresh_q;

	always_comb begin
		base_heading = clr_in ? start_heading_q : heading_q;
		turn         = ({1'b0, in_data.turn_index} < (TURN_IDX_W+1)'(NUM_TURNS))
			? turn_angle_q[in_data.turn_index] : '0;
		next_heading = base_heading + turn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			fresh_q   <= 1'b1;
		end else if (in_acc) begin
			heading_q <= next_heading;
			fresh_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_acc;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			heading_s1 <= next_heading;
			clr_s1     <= clr_in;
			clr_s2     <= clr_s1;
			clr_s3     <= clr_s2;
			prod_x_s3  <= PROD_W'($signed({1'b0, step_length_q}) * cos_s2);
			prod_y_s3  <= PROD_W'($signed({1'b0, step_length_q}) * sin_s2);
		end
	end

	tsbb_sine_rom u_sine_rom (
		.clk     (clk),
		.en      (advance),
		.heading (heading_s1),
		.sin_val (sin_s2),
		.cos_val (cos_s2)
	);

	// a restarting word starts from the origin with bounds collapsed onto the origin
	always_comb begin
		pos_x_base = clr_s3 ? '0 : pos_x_q;
		pos_y_base = clr_s3 ? '0 : pos_y_q;
		min_x_base = clr_s3 ? '0 : min_x_q;
		max_x_base = clr_s3 ? '0 : max_x_q;
		min_y_base = clr_s3 ? '0 : min_y_q;
		max_y_base = clr_s3 ? '0 : max_y_q;
		delta_x    = round_q16(prod_x_s3);
		delta_y    = round_q16(prod_y_s3);
		pos_x_new  = sat_add(pos_x_base, delta_x);
		pos_y_new  = sat_add(pos_y_base, delta_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			min_x_q <= '0;
			max_x_q <= '0;
			min_y_q <= '0;
			max_y_q <= '0;
		end else if (advance && valid_s3) begin
			pos_x_q <= pos_x_new;
			pos_y_q <= pos_y_new;
			min_x_q <= (pos_x_new < min_x_base) ? pos_x_new : min_x_base;
			max_x_q <= (pos_x_new > max_x_base) ? pos_x_new : max_x_base;
			min_y_q <= (pos_y_new < min_y_base) ? pos_y_new : min_y_base;
			max_y_q <= (pos_y_new > max_y_base) ? pos_y_new : max_y_base;
		end
	end

	assign center_x_sum = {min_x_q[POS_W-1], min_x_q} + {max_x_q[POS_W-1], max_x_q};
	assign center_y_sum = {min_y_q[POS_W-1], min_y_q} + {max_y_q[POS_W-1], max_y_q};

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q.point_x  <= pos_x_q;
			out_word_q.point_y  <= pos_y_q;
			out_word_q.center_x <= center_x_sum[POS_W:1];
			out_word_q.center_y <= center_y_sum[POS_W:1];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	a_origin_x: assert property (@(posedge clk) disable iff (!arst_n)
		min_x_q <= 0 && max_x_q >= 0)
		else $error("x bounds lost the origin");

	a_origin_y: assert property (@(posedge clk) disable iff (!arst_n)
		min_y_q <= 0 && max_y_q >= 0)
		else $error("y bounds lost the origin");

	a_pos_inside: assert property (@(posedge clk) disable iff (!arst_n)
		min_x_q <= pos_x_q && pos_x_q <= max_x_q && min_y_q <= pos_y_q && pos_y_q <= max_y_q)
		else $error("position outside bounds");

	a_fresh_on_word: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(fresh_q) |-> $past(in_valid && in_ready))
		else $error("fresh flag cleared without an accepted word");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pos_x_q) && $stable(pos_y_q) && $stable(heading_q))
		else $error("state moved during a stall");

endmodule

`default_nettype wire

### src/tsbb_sine_rom.sv
// quadrant-folded sine and cosine lookup with registered outputs
`timescale 1ns / 1ps
`default_nettype none

module tsbb_sine_rom
	import tsbb_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [ANGLE_W-1:0]         heading,
	output logic signed [TRIG_W-1:0]        sin_val,
	output logic signed [TRIG_W-1:0]        cos_val
);

	logic [ANGLE_W-1:0]     cos_heading;
	logic [SINE_ADDR_W-1:0] sin_addr;
	logic [SINE_ADDR_W-1:0] cos_addr;
	logic [SINE_MAG_W-1:0]  sin_mag_q;
	logic [SINE_MAG_W-1:0]  cos_mag_q;
	logic                   sin_neg_q;
	logic                   cos_neg_q;

	// odd quadrants read the table mirrored
	function automatic logic [SINE_ADDR_W-1:0] quarter_addr(input logic [ANGLE_W-1:0] h);
		logic [SINE_ADDR_W-1:0] f;
		f = {1'b0, h[ANGLE_W-3 -: SINE_TABLE_BITS]};
		return h[ANGLE_W-2] ? (SINE_ADDR_W'(QSTEPS) - f) : f;
	endfunction

	assign cos_heading = heading + COS_OFFSET;
	assign sin_addr    = quarter_addr(heading);
	assign cos_addr    = quarter_addr(cos_heading);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_q <= SINE_TAB[sin_addr];
			cos_mag_q <= SINE_TAB[cos_addr];
			sin_neg_q <= heading[ANGLE_W-1];
			cos_neg_q <= cos_heading[ANGLE_W-1];
		end
	end

	// lower half of the circle is negative
	assign sin_val = sin_neg_q ? -$signed({1'b0, sin_mag_q}) : $signed({1'b0, sin_mag_q});
	assign cos_val = cos_neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});

endmodule

`default_nettype wire

### sim/tb_turtle_step_bounding_box.sv
// testbench for the turtle step walker: random handshakes, self-checking path and bounds predictor
`timescale 1ns / 1ps

module tb_turtle_step_bounding_box
	import tsbb_pkg::*;
();

	localparam int STALL_LIMIT     = 2000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int PHASES          = 9;
	localparam int STEPS_PER_PHASE = 125;
	localparam int REPORT_LIMIT    = 10;

	// register slots that decode to nothing
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum int {MIX_WILD, MIX_RUNAWAY, MIX_CORNERS} phase_kind_e;

	class path_tracker;
		logic [ANGLE_W-1:0]    turns [TURN_SLOTS];
		logic [ANGLE_W-1:0]    home_dir;
		logic [CFG_DATA_W-1:0] stride;
		logic [ANGLE_W-1:0]    dir;
		bit                    need_home;
		int                    cur_x, cur_y, lo_x, hi_x, lo_y, hi_y;
		int                    quarter_wave [QSTEPS+1];
		out_word_t             points_due [$];
		int                    errors;
		int                    seen;

		function new();
			longint unsigned ang, sq, t, v;
			longint          acc;
			for (int k = 0; k < QSTEPS; k++) begin
				ang = (HALF_PI_Q30 * k) / QSTEPS;
				sq  = (ang * ang) >> 30;
				t   = ang;
				acc = ang;
				// alternating taylor terms up to x^13
				for (int n = 1; n <= 6; n++) begin
					t = ((t * sq) >> 30) / ((2 * n) * (2 * n + 1));
					if (n % 2 == 1) begin
						acc = acc - longint'(t);
					end else begin
						acc = acc + longint'(t);
					end
				end
				if (acc < 0) begin
					acc = 0;
				end
				v = (acc + 8192) >> 14;
				if (v > ONE_Q16) begin
					v = ONE_Q16;
				end
				quarter_wave[k] = int'(v);
			end
			quarter_wave[QSTEPS] = int'(ONE_Q16);
			foreach (turns[i]) begin
				turns[i] = '0;
			end
			home_dir  = '0;
			stride    = STEP_LENGTH_RESET;
			dir       = '0;
			need_home = 1'b1;
			cur_x = 0; cur_y = 0;
			lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
			errors = 0;
			seen   = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_TURN_A:        turns[0] = val;
				CFG_TURN_B:        turns[1] = val;
				CFG_TURN_C:        turns[2] = val;
				CFG_TURN_D:        turns[3] = val;
				CFG_START_HEADING: home_dir = val;
				CFG_STEP_LENGTH:   stride   = val;
				default: ;
			endcase
		endfunction

		function int sine_of(logic [ANGLE_W-1:0] h);
			logic [1:0] q;
			int         f;
			int         mag;
			q   = h[ANGLE_W-1 -: 2];
			f   = int'(h[ANGLE_W-3 -: SINE_TABLE_BITS]);
			mag = q[0] ? quarter_wave[QSTEPS - f] : quarter_wave[f];
			return q[1] ? -mag : mag;
		endfunction

		// move one coordinate by stride * trig, rounded to q16, clamped to 32 bits
		function int advance(int p, int trig);
			longint d;
			longint r;
			d = (longint'(stride) * trig + 128) >>> STEP_FRAC;
			r = longint'(p) + d;
			if (r > longint'(32'sh7fff_ffff)) begin
				r = longint'(32'sh7fff_ffff);
			end
			if (r < -longint'(64'sh8000_0000)) begin
				r = -longint'(64'sh8000_0000);
			end
			return int'(r);
		endfunction

		function int midpoint(int a, int b);
			longint s;
			s = longint'(a) + longint'(b);
			return int'(s >>> 1);
		endfunction

		function void take_step(in_word_t w);
			logic [ANGLE_W-1:0] turn;
			out_word_t          want;
			if (w.restart || need_home) begin
				dir = home_dir;
				cur_x = 0; cur_y = 0;
				lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
				need_home = 1'b0;
			end
			turn = (int'(w.turn_index) < NUM_TURNS) ? turns[w.turn_index] : '0;
			dir   = dir + turn;
			cur_x = advance(cur_x, sine_of(dir + COS_OFFSET));
			cur_y = advance(cur_y, sine_of(dir));
			if (cur_x < lo_x) lo_x = cur_x;
			if (cur_x > hi_x) hi_x = cur_x;
			if (cur_y < lo_y) lo_y = cur_y;
			if (cur_y > hi_y) hi_y = cur_y;
			want.point_x  = cur_x;
			want.point_y  = cur_y;
			want.center_x = midpoint(lo_x, hi_x);
			want.center_y = midpoint(lo_y, hi_y);
			points_due.push_back(want);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= REPORT_LIMIT) begin
				$display("mismatch: %s", msg);
			end
		endfunction

		function void field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
			if (got !== want) begin
				flag($sformatf("word %0d %s expected %0d got %0d", seen, name,
					$signed(want), $signed(got)));
			end
		endfunction

		function void compare_point(out_word_t got);
			out_word_t want;
			if (points_due.size() == 0) begin
				flag($sformatf("word %0d arrived with nothing pending", seen));
			end else begin
				want = points_due.pop_front();
				field("point_x", want.point_x, got.point_x);
				field("point_y", want.point_y, got.point_y);
				field("center_x", want.center_x, got.center_x);
				field("center_y", want.center_y, got.center_y);
			end
			seen++;
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_word_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_word_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	path_tracker tracker;
	bit          tx_gaps;
	bit          rx_stalls;
	int          hold;
	int          still;

	turtle_step_bounding_box dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (hold > 0) begin
			hold--;
			out_ready <= 1'b0;
		end else if (rx_stalls && $urandom_range(0, 9) == 0) begin
			hold = $urandom_range(0, 18);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.compare_point(out_data);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			still = 0;
		end else begin
			still++;
		end
		if (still >= STALL_LIMIT) begin
			$display("[turtle_step_bounding_box] ERROR");
			$finish;
		end
	end

	task automatic send_step(input logic [TURN_IDX_W-1:0] idx, input logic rs);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{turn_index: idx, restart: rs};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.take_step('{turn_index: idx, restart: rs});
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	task automatic load_settings(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d, input logic [15:0] home,
			input logic [15:0] len, input bit spares);
		write_cfg(CFG_TURN_A, a);
		write_cfg(CFG_TURN_B, b);
		write_cfg(CFG_TURN_C, c);
		write_cfg(CFG_TURN_D, d);
		write_cfg(CFG_START_HEADING, home);
		if (spares) begin
			write_cfg(CFG_SPARE_LO, 16'($urandom));
			write_cfg(CFG_SPARE_HI, 16'($urandom));
		end
		write_cfg(CFG_STEP_LENGTH, len);
		cfg_valid <= 1'b0;
	endtask

	// stop sending and let the pipe empty
	task automatic await_points();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.points_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] corner_val();
		case ($urandom_range(0, 8))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'h3fff;
			3: return 16'h4000;
			4: return 16'h4001;
			5: return 16'h8000;
			6: return 16'hc000;
			7: return 16'hfffe;
			default: return 16'hffff;
		endcase
	endfunction

	function automatic logic [15:0] nudge_val();
		case ($urandom_range(0, 2))
			0: return 16'h0000;
			1: return 16'h0001;
			default: return 16'hffff;
		endcase
	endfunction

	initial begin
		phase_kind_e        kind;
		logic [15:0]        home;
		logic               rs;
		tracker   = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TURN_A;
		cfg_data  = '0;
		hold      = 0;
		still     = 0;
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset, first word restarts on its own
		send_step(2'd0, 1'b0);
		send_step(2'd1, 1'b0);
		send_step(2'd2, 1'b0);
		send_step(2'd3, 1'b0);
		send_step(2'd0, 1'b1);
		await_points();

		// quarter turns, full-scale stride, wrapped start heading
		load_settings(16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'hffff, 16'hffff, 1'b1);
		send_step(2'd0, 1'b1);
		send_step(2'd1, 1'b0);
		send_step(2'd2, 1'b0);
		send_step(2'd3, 1'b0);
		send_step(2'd0, 1'b0);
		send_step(2'd3, 1'b1);
		send_step(2'd2, 1'b0);
		await_points();

		// zero stride keeps the point where it was
		load_settings(16'h0000, 16'h0001, 16'hffff, 16'h8000, 16'h4000, 16'h0000, 1'b0);
		send_step(2'd0, 1'b0);
		send_step(2'd1, 1'b0);
		send_step(2'd2, 1'b0);
		send_step(2'd3, 1'b1);
		await_points();

		// smallest nonzero stride, rounding of negative steps
		load_settings(16'h2000, 16'he000, 16'h6000, 16'ha000, 16'hc000, 16'h0001, 1'b0);
		send_step(2'd0, 1'b1);
		send_step(2'd1, 1'b0);
		send_step(2'd2, 1'b0);
		send_step(2'd3, 1'b0);
		send_step(2'd1, 1'b1);
		await_points();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1, 4: kind = MIX_RUNAWAY;
				2, 6: kind = MIX_CORNERS;
				default: kind = MIX_WILD;
			endcase
			tx_gaps   = (p != 5) && (p != PHASES - 1);
			rx_stalls = tx_gaps;
			case (kind)
				MIX_RUNAWAY: begin
					// axis-aligned heading so the walk runs far along one axis
					home = 16'($urandom_range(0, 3)) << 14;
					load_settings(nudge_val(), nudge_val(), nudge_val(), nudge_val(), home,
						16'hffff - 16'($urandom_range(0, 3)), p[0]);
				end
				MIX_CORNERS: begin
					load_settings(corner_val(), corner_val(), corner_val(), corner_val(),
						corner_val(), corner_val(), p[0]);
				end
				default: begin
					load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), p[0]);
				end
			endcase
			for (int i = 0; i < STEPS_PER_PHASE; i++) begin
				if (kind == MIX_RUNAWAY) begin
					rs = (i == 0);
				end else begin
					rs = ($urandom_range(0, 39) == 0) || (i == 0 && $urandom_range(0, 1) == 0);
				end
				if (p == 3 && i == STEPS_PER_PHASE / 2) begin
					await_points();
				end
				send_step(TURN_IDX_W'($urandom_range(0, 3)), rs);
			end
			await_points();
		end

		if (tracker.points_due.size() != 0) begin
			tracker.flag($sformatf("%0d words never arrived", tracker.points_due.size()));
		end
		if (tracker.errors == 0) begin
			$display("[turtle_step_bounding_box] OK");
		end else begin
			$display("[turtle_step_bounding_box] ERROR");
		end
		$finish;
	end

endmodule
